// ----- rtl/core/ltpm_pkg.sv -----
// Package for the line text pattern matcher core.
// Holds widths, operation and register codes and the shared payload types.
// Used by the channel interfaces, the window cells, the output buffer and the top level.
`default_nettype none

package ltpm_pkg;

   localparam int PATTERN_BYTES       = 16;
   localparam int SEL_W               = $clog2(PATTERN_BYTES);
   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int LEN_W               = 5;
   localparam int COUNT_W             = 16;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 64;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_TEXT       = 2'd0,
      OP_LINE_BREAK = 2'd1,
      OP_END_TEXT   = 2'd2
   } op_type;

   typedef enum logic {
      RESULT_MATCH = 1'b0,
      RESULT_TOTAL = 1'b1
   } result_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   typedef logic [PATTERN_BYTES-1:0][7:0] pattern_type;

   typedef struct packed {
      logic               result_kind;
      logic [COUNT_W-1:0] match_line;
      logic [COUNT_W-1:0] match_column;
      logic [COUNT_W-1:0] match_total;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- rtl/core/ltpm_channels.sv -----
// Valid/ready channel interfaces for the request, response and register write ports.
// Depends on ltpm_pkg for field widths.
`default_nettype none

interface ltpm_req_if;
   import ltpm_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] text_byte;
   modport source (output valid, output operation, output text_byte, input ready);
   modport sink (input valid, input operation, input text_byte, output ready);
endinterface

interface ltpm_rsp_if;
   import ltpm_pkg::*;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [COUNT_W-1:0] match_line;
   logic [COUNT_W-1:0] match_column;
   logic [COUNT_W-1:0] match_total;
   modport source (output valid, output result_kind, output match_line,
                   output match_column, output match_total, input ready);
   modport sink (input valid, input result_kind, input match_line,
                 input match_column, input match_total, output ready);
endinterface

interface ltpm_csr_if;
   import ltpm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/line_text_pattern_matcher_core.sv -----
// Top level of the line text pattern matcher: registers, counters, the cell chain
// and the response buffer. Depends on ltpm_pkg, ltpm_channels, ltpm_cell and
// ltpm_out_buffer.
//
// Text enters on req_chan one request per byte, with separate requests for a line
// break and for end of text. The pattern and its length are written on csr_chan,
// which is always ready; writes must go in while the core is idle, as the block
// does not enforce it. Each text byte moves down a chain of MAX_PATTERN cells,
// each comparing its incoming byte with its pattern byte, so a request is taken
// every cycle unless the buffer is full. A match or the end-of-text total enters
// the buffer as its request is accepted. Matches do not overlap and do not cross
// lines. Reset clears the window and all counters, zeroes the pattern and sets
// its length to one. When the receiver stalls, a two-entry response buffer keeps
// requests flowing; req_chan.ready drops only once both entries hold results.
`default_nettype none

module line_text_pattern_matcher_core #(
   parameter int MAX_PATTERN = ltpm_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ltpm_req_if.sink   req_chan,
   ltpm_rsp_if.source rsp_chan,
   ltpm_csr_if.sink   csr_chan
);
   import ltpm_pkg::*;

   localparam int               RUN_W   = $clog2(MAX_PATTERN + 1);
   localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_PATTERN);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

   logic [CSR_DATA_W-1:0] pattern_low_ff;
   logic [CSR_DATA_W-1:0] pattern_high_ff;
   logic [LEN_W-1:0]      pattern_length_ff;
   logic [RUN_W-1:0]      fresh_run_ff;
   logic [RUN_W-1:0]      fresh_run_in;
   logic [COUNT_W-1:0]    column_ff;
   logic [COUNT_W-1:0]    column_in;
   logic [COUNT_W-1:0]    line_ff;
   logic [COUNT_W-1:0]    line_in;
   logic [COUNT_W-1:0]    found_ff;
   logic [COUNT_W-1:0]    found_in;

   pattern_type           pattern;
   logic [LEN_W-1:0]      eff_len;
   logic [MAX_PATTERN-1:0][7:0] chain_bytes;
   logic [MAX_PATTERN-1:0] cell_hit;
   logic                  accept;
   logic                  is_text;
   logic                  is_line;
   logic                  is_end;
   logic [RUN_W-1:0]      run_next;
   logic [COUNT_W-1:0]    found_next;
   logic                  match;
   logic                  push;
   logic                  space;
   rsp_payload_type       push_data;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= LEN_W'(1);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PATTERN_LOW:  pattern_low_ff    <= csr_chan.data;
            CSR_PATTERN_HIGH: pattern_high_ff   <= csr_chan.data;
            CSR_PATTERN_LEN:  pattern_length_ff <= csr_chan.data[LEN_W-1:0];
            default:          ;
         endcase
      end
   end

   assign pattern = {pattern_high_ff, pattern_low_ff};
   assign eff_len = (pattern_length_ff > LEN_MAX) ? LEN_MAX : pattern_length_ff;

   assign accept  = req_chan.valid && req_chan.ready;
   assign is_text = accept && (req_chan.operation == OP_TEXT);
   assign is_line = accept && (req_chan.operation == OP_LINE_BREAK);
   assign is_end  = accept && (req_chan.operation == OP_END_TEXT);

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      ltpm_cell #(
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (is_text),
         .clear    (is_end),
         .data_in  ((i == 0) ? req_chan.text_byte : chain_bytes[(i == 0) ? 0 : i - 1]),
         .pattern  (pattern),
         .eff_len  (eff_len),
         .data_out (chain_bytes[i]),
         .hit      (cell_hit[i])
      );
   end

   assign run_next   = (fresh_run_ff >= RUN_MAX) ? RUN_MAX : fresh_run_ff + RUN_W'(1);
   assign found_next = (found_ff == COUNT_MAX) ? COUNT_MAX : found_ff + COUNT_W'(1);
   assign match      = is_text && (eff_len != '0) && (LEN_W'(run_next) >= eff_len)
                       && (&cell_hit);

   always_comb begin
      fresh_run_in = fresh_run_ff;
      column_in    = column_ff;
      line_in      = line_ff;
      found_in     = found_ff;
      if (is_text) begin
         fresh_run_in = match ? '0 : run_next;
         column_in    = (column_ff == COUNT_MAX) ? COUNT_MAX : column_ff + COUNT_W'(1);
         if (match) begin
            found_in = found_next;
         end
      end else if (is_line) begin
         fresh_run_in = '0;
         column_in    = '0;
         line_in      = (line_ff == COUNT_MAX) ? COUNT_MAX : line_ff + COUNT_W'(1);
      end else if (is_end) begin
         fresh_run_in = '0;
         column_in    = '0;
         line_in      = '0;
         found_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_run_ff <= '0;
         column_ff    <= '0;
         line_ff      <= '0;
         found_ff     <= '0;
      end else begin
         fresh_run_ff <= fresh_run_in;
         column_ff    <= column_in;
         line_ff      <= line_in;
         found_ff     <= found_in;
      end
   end

   always_comb begin
      if (is_end) begin
         push_data.result_kind  = RESULT_TOTAL;
         push_data.match_line   = '0;
         push_data.match_column = '0;
         push_data.match_total  = found_ff;
      end else begin
         push_data.result_kind  = RESULT_MATCH;
         push_data.match_line   = line_ff;
         push_data.match_column = column_ff - (COUNT_W'(eff_len) - COUNT_W'(1));
         push_data.match_total  = found_next;
      end
   end

   assign push = match || is_end;

   ltpm_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .space     (space),
      .rsp_chan  (rsp_chan)
   );

   assign req_chan.ready = space;

`ifndef SYNTH
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("request side stalled with no response waiting");

   a_end_clears_total: assert property (@(posedge clock) disable iff (reset)
      is_end |=> (found_ff == '0) && (line_ff == '0) && (column_ff == '0))
      else $error("end of text did not clear the counters");

   a_match_restarts_run: assert property (@(posedge clock) disable iff (reset)
      match |=> (fresh_run_ff == '0) && (found_ff != '0))
      else $error("match did not restart the run or count");

   a_push_gives_valid: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_chan.valid)
      else $error("accepted result not presented");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ltpm_cell.sv -----
// One window cell: holds one recent text byte and compares the incoming byte
// with the pattern byte that lines up with its position. Depends on ltpm_pkg.
`default_nettype none

module ltpm_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        shift_en,
   input  wire logic                        clear,
   input  wire logic [7:0]                  data_in,
   input  wire ltpm_pkg::pattern_type       pattern,
   input  wire logic [ltpm_pkg::LEN_W-1:0]  eff_len,
   output logic      [7:0]                  data_out,
   output logic                             hit
);
   import ltpm_pkg::*;

   localparam logic [LEN_W-1:0] CELL_POS = LEN_W'(INDEX);

   logic [7:0]       byte_ff;
   logic [7:0]       byte_in;
   logic [LEN_W-1:0] pat_index;

   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = 8'd0;
      end else if (shift_en) begin
         byte_in = data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign pat_index = eff_len - CELL_POS - LEN_W'(1);
   assign hit       = (eff_len <= CELL_POS) || (data_in == pattern[pat_index[SEL_W-1:0]]);
   assign data_out  = byte_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ltpm_out_buffer.sv -----
// Two-entry response buffer: an output register with a skid slot behind it.
// Depends on ltpm_pkg and the response channel interface.
`default_nettype none

module ltpm_out_buffer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire ltpm_pkg::rsp_payload_type push_data,
   output logic                          space,
   ltpm_rsp_if.source                    rsp_chan
);
   import ltpm_pkg::*;

   logic            main_valid_ff;
   logic            main_valid_in;
   logic            skid_valid_ff;
   logic            skid_valid_in;
   rsp_payload_type main_data_ff;
   rsp_payload_type main_data_in;
   rsp_payload_type skid_data_ff;
   rsp_payload_type skid_data_in;
   logic            pop;

   assign pop = main_valid_ff && rsp_chan.ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (main_valid_ff && !pop) begin
         if (push) begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (push) begin
         main_data_in  = push_data;
         main_valid_in = 1'b1;
      end else begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space                 = !skid_valid_ff;
   assign rsp_chan.valid        = main_valid_ff;
   assign rsp_chan.result_kind  = main_data_ff.result_kind;
   assign rsp_chan.match_line   = main_data_ff.match_line;
   assign rsp_chan.match_column = main_data_ff.match_column;
   assign rsp_chan.match_total  = main_data_ff.match_total;

endmodule

`default_nettype wire

// ----- sim/ltpm_match_checker.sv -----
// Checker for the line text pattern matcher: follows register writes and accepted requests,
// predicts the match and total reports, and compares them with the responses.
// Depends on ltpm_pkg and the channel interfaces in ltpm_channels.
`default_nettype none

module ltpm_match_checker
   import ltpm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ltpm_req_if       req_mon,
   ltpm_rsp_if       rsp_mon,
   ltpm_csr_if       csr_mon,
   output int        fail_count,
   output int        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   pattern_type        pattern_q;
   logic [LEN_W-1:0]   length_q;
   logic [7:0]         window_q [PATTERN_BYTES];
   logic [LEN_W-1:0]   run_q;
   logic [COUNT_W-1:0] column_q;
   logic [COUNT_W-1:0] line_q;
   logic [COUNT_W-1:0] found_q;
   rsp_payload_type    predicted_reports [$];

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   task automatic scan_request(input logic [1:0] op_bits, input logic [7:0] text);
      int                 len;
      logic [COUNT_W-1:0] col;
      bit                 hit;
      rsp_payload_type    report;
      case (op_bits)
         OP_TEXT: begin
            len = (length_q > MAX_PATTERN_DEFAULT) ? MAX_PATTERN_DEFAULT : int'(length_q);
            col = column_q;
            for (int i = PATTERN_BYTES - 1; i > 0; i--) window_q[i] = window_q[i - 1];
            window_q[0] = text;
            if (run_q < MAX_PATTERN_DEFAULT) run_q++;
            if (column_q != COUNT_MAX) column_q++;
            hit = (len != 0) && (int'(run_q) >= len);
            for (int k = 0; k < len; k++) begin
               if (window_q[len - 1 - k] != pattern_q[k]) hit = 1'b0;
            end
            if (hit) begin
               run_q = '0;
               if (found_q != COUNT_MAX) found_q++;
               report.result_kind  = RESULT_MATCH;
               report.match_line   = line_q;
               report.match_column = col - COUNT_W'(len - 1);
               report.match_total  = found_q;
               predicted_reports.push_back(report);
            end
         end
         OP_LINE_BREAK: begin
            run_q    = '0;
            column_q = '0;
            if (line_q != COUNT_MAX) line_q++;
         end
         OP_END_TEXT: begin
            report.result_kind  = RESULT_TOTAL;
            report.match_line   = '0;
            report.match_column = '0;
            report.match_total  = found_q;
            predicted_reports.push_back(report);
            foreach (window_q[i]) window_q[i] = '0;
            run_q    = '0;
            column_q = '0;
            line_q   = '0;
            found_q  = '0;
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         pattern_q  = '0;
         length_q   = LEN_W'(1);
         foreach (window_q[i]) window_q[i] = '0;
         run_q      = '0;
         column_q   = '0;
         line_q     = '0;
         found_q    = '0;
         fail_count = 0;
         predicted_reports.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_PATTERN_LOW:  pattern_q[7:0]  = csr_mon.data;
               CSR_PATTERN_HIGH: pattern_q[15:8] = csr_mon.data;
               CSR_PATTERN_LEN:  length_q        = csr_mon.data[LEN_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_reports.size() == 0) begin
               $error("response with no request waiting: kind %0d line %0d column %0d total %0d",
                      rsp_mon.result_kind, rsp_mon.match_line, rsp_mon.match_column,
                      rsp_mon.match_total);
               fail_count++;
            end else begin
               want = predicted_reports.pop_front();
               check_field("result_kind", want.result_kind, rsp_mon.result_kind);
               check_field("match_line", want.match_line, rsp_mon.match_line);
               check_field("match_column", want.match_column, rsp_mon.match_column);
               check_field("match_total", want.match_total, rsp_mon.match_total);
            end
         end
         if (req_mon.valid && req_mon.ready) scan_request(req_mon.operation, req_mon.text_byte);
      end
      pending <= predicted_reports.size();
   end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench top for line_text_pattern_matcher_core: clock, reset, request and register
// stimulus with bursty sending and a stalling receiver, and the final verdict.
// Depends on ltpm_pkg, the channel interfaces, the core and ltpm_match_checker.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ltpm_pkg::*;

   localparam logic [1:0]             OP_UNUSED  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int                     TEXT_ITEMS = 1700;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ltpm_req_if req_chan ();
   ltpm_rsp_if rsp_chan ();
   ltpm_csr_if csr_chan ();

   int fail_count;
   int expected_count;

   line_text_pattern_matcher_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   ltpm_match_checker match_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (expected_count)
   );

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   bit rx_free = 1'b0;
   bit rx_on   = 1'b0;
   int rx_left = 0;

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_on   = !rx_on;
         rx_left = rx_on ? (($urandom_range(0, 7) == 0) ? 50 : $urandom_range(1, 10))
                         : $urandom_range(1, 6);
      end
      rx_left--;
      rsp_chan.ready <= rx_on || rx_free;
   end

   bit          tx_free = 1'b0;
   int          burst_left = 0;
   int          sent_items = 0;
   pattern_type gen_pattern;
   int          gen_len = 1;

   task automatic send_req(input logic [1:0] op, input logic [7:0] text);
      if (!tx_free && burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.text_byte <= text;
      do @(posedge clock); while (!req_chan.ready);
      if (burst_left > 0) burst_left--;
      if (op != OP_UNUSED) sent_items++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic set_pattern(input pattern_type pattern, input logic [LEN_W-1:0] len);
      logic [CSR_DATA_W-1:0] len_word;
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = len;
      if ($urandom_range(0, 3) != 0) len_word[CSR_DATA_W-1:LEN_W] = '0;
      write_csr(CSR_PATTERN_LOW, pattern[7:0]);
      write_csr(CSR_PATTERN_HIGH, pattern[15:8]);
      write_csr(CSR_PATTERN_LEN, len_word);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_UNUSED, {$urandom, $urandom});
      csr_chan.valid <= 1'b0;
      @(posedge clock);
      gen_pattern = pattern;
      gen_len = (len == 0) ? 1 : ((len > MAX_PATTERN_DEFAULT) ? MAX_PATTERN_DEFAULT : len);
   endtask

   initial begin : stimulus
      int               r;
      int               cut;
      int               mut;
      int               phase_end;
      int               wait_cycles;
      logic [7:0]       alphabet [3];
      logic [7:0]       text;
      pattern_type      pattern;
      logic [LEN_W-1:0] len;

      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_TEXT;
      req_chan.text_byte <= 8'h00;
      csr_chan.valid     <= 1'b0;
      csr_chan.index     <= CSR_PATTERN_LOW;
      csr_chan.data      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // After reset the pattern is a single zero byte.
      send_req(OP_TEXT, 8'h00);
      send_req(OP_TEXT, 8'hFF);
      send_req(OP_UNUSED, 8'h00);
      send_req(OP_LINE_BREAK, 8'h00);
      send_req(OP_TEXT, 8'h00);
      send_req(OP_END_TEXT, 8'h00);
      drain();

      set_pattern(pattern_type'(128'h4141), LEN_W'(2));
      repeat (5) send_req(OP_TEXT, 8'h41);
      send_req(OP_LINE_BREAK, 8'hFF);
      send_req(OP_TEXT, 8'h41);
      send_req(OP_LINE_BREAK, 8'h00);
      send_req(OP_TEXT, 8'h41);
      send_req(OP_TEXT, 8'h41);
      send_req(OP_END_TEXT, 8'hFF);
      drain();

      set_pattern(pattern_type'(128'hFF00FF), LEN_W'(3));
      send_req(OP_TEXT, 8'hFF);
      send_req(OP_TEXT, 8'h00);
      send_req(OP_TEXT, 8'hFF);
      drain();

      // A zero length never matches, here applied in the middle of a line.
      set_pattern('0, LEN_W'(0));
      send_req(OP_TEXT, 8'h00);
      send_req(OP_TEXT, 8'h00);
      send_req(OP_END_TEXT, 8'h00);

      while (sent_items < TEXT_ITEMS) begin
         drain();
         tx_free = ($urandom_range(0, 5) == 0);
         rx_free = ($urandom_range(0, 5) == 0);
         for (int j = 0; j < 3; j++) begin
            r = $urandom_range(0, 3);
            alphabet[j] = (r == 0) ? 8'h00 : ((r == 1) ? 8'hFF : 8'($urandom));
         end
         for (int j = 0; j < PATTERN_BYTES; j++)
            pattern[j] = ($urandom_range(0, 4) != 0) ? alphabet[$urandom_range(0, 2)]
                                                      : 8'($urandom);
         r = $urandom_range(0, 99);
         if (r < 60) len = LEN_W'($urandom_range(1, 4));
         else if (r < 80) len = LEN_W'($urandom_range(5, 16));
         else if (r < 90) len = LEN_W'($urandom_range(17, 31));
         else if (r < 95) len = '0;
         else len = LEN_W'(MAX_PATTERN_DEFAULT);
         set_pattern(pattern, len);

         phase_end = sent_items + $urandom_range(20, 90);
         while (sent_items < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
               mut = $urandom_range(0, 3 * gen_len);
               for (int k = 0; k < gen_len; k++)
                  send_req(OP_TEXT, (k == mut) ? 8'($urandom) : gen_pattern[k]);
            end else if (r < 40) begin
               cut = $urandom_range(1, gen_len);
               for (int k = 0; k < cut; k++) send_req(OP_TEXT, gen_pattern[k]);
            end else if (r < 85) begin
               text = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                  : alphabet[$urandom_range(0, 2)];
               send_req(OP_TEXT, text);
            end else if (r < 92) begin
               send_req(OP_LINE_BREAK, 8'($urandom));
            end else if (r < 94) begin
               send_req(OP_END_TEXT, 8'($urandom));
            end else if (r < 97) begin
               send_req(OP_UNUSED, 8'($urandom));
            end else if ($urandom_range(0, 9) == 0) begin
               drain();
            end else begin
               send_req(OP_TEXT, alphabet[$urandom_range(0, 2)]);
            end
         end
         if ($urandom_range(0, 1) == 0) send_req(OP_END_TEXT, 8'($urandom));
      end

      req_chan.valid <= 1'b0;
      wait_cycles = 0;
      @(posedge clock);
      while (expected_count != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- line_text_pattern_matcher_core.f -----
rtl/core/ltpm_pkg.sv
rtl/core/ltpm_channels.sv
rtl/core/ltpm_cell.sv
rtl/core/ltpm_out_buffer.sv
rtl/core/line_text_pattern_matcher_core.sv
sim/ltpm_match_checker.sv
sim/tb.sv
